FILE: rtl/weighted_resample_index_search_defines.svh
// Assertion macros for the resample index search block.
`ifndef WEIGHTED_RESAMPLE_INDEX_SEARCH_DEFINES_SVH
`define WEIGHTED_RESAMPLE_INDEX_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS

`define WRS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define WRS_ASSERT_NEXT(lbl, clk, rstn, trig, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (prop)) else $error(msg);

`else

`define WRS_ASSERT(lbl, clk, rstn, prop, msg)

`define WRS_ASSERT_NEXT(lbl, clk, rstn, trig, prop, msg)

`endif

`endif

FILE: rtl/wrs_pkg.sv
`timescale 1ns / 1ps

package wrs_pkg;

    localparam int MAX_PARTICLES_DEF = 1024;
    localparam int WEIGHT_BITS_DEF   = 16;

    localparam int WEIGHT_IN_W = 16;
    localparam int FRAC_W      = 16;
    localparam int IDX_OUT_W   = 10;
    localparam int DIGIT_W     = 4;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_DRAW = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } wrs_mul_stat_t;

endpackage

FILE: rtl/weighted_resample_index_search.sv
`timescale 1ns / 1ps
// Load: accepted every cycle while idle; first-of-set restarts the table at entry 0, others
// append at the accepting edge unless full. Draw: the 4-step shift-add scaler forms the
// target, then each search step reads the table in SRCH and compares in CMP; a draw with
// empty set or zero total goes straight to FIN. s_ready returns the cycle after the result
// is loaded into the output register. Stalls on m_ready hold the block in its last step.
// Reset (synchronous, aresetn low) clears count, total and control; table is not cleared.
`include "weighted_resample_index_search_defines.svh"

module weighted_resample_index_search #(
    parameter int MAX_PARTICLES = wrs_pkg::MAX_PARTICLES_DEF,
    parameter int WEIGHT_BITS   = wrs_pkg::WEIGHT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [15:0] s_weight_value,
    input  logic        s_first_of_set,
    input  logic [15:0] s_draw_fraction,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_chosen_index,
    output logic        m_zero_total
);

    import wrs_pkg::*;

    localparam int IDX_W = $clog2(MAX_PARTICLES);
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
    localparam int SUM_W = WEIGHT_BITS + IDX_W;
    localparam int W_IN  = (WEIGHT_BITS < WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;
    localparam logic [WEIGHT_IN_W-1:0] W_MASK = WEIGHT_IN_W'((64'd1 << W_IN) - 64'd1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SRCH = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SUM_W-1:0] total_reg, total_next;
    logic [IDX_W-1:0] lo_reg, lo_next, hi_reg, hi_next, mid;
    logic [IDX_W-1:0] res_idx_reg, res_idx_next;
    logic             res_zero_reg, res_zero_next;
    logic             m_valid_reg;
    logic [IDX_W-1:0] m_idx_reg;
    logic             m_zero_reg;
    logic [IDX_W+IDX_OUT_W-1:0] idx_wide;

    logic             s_fire, out_load, mul_start, wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [SUM_W-1:0] w_ext, rd_data, target;
    wrs_mul_stat_t    mul_stat;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign w_ext    = SUM_W'(s_weight_value & W_MASK);
    assign mid      = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign out_load = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        total_next    = total_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        res_idx_next  = res_idx_reg;
        res_zero_next = res_zero_reg;
        mul_start     = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = cnt_reg[IDX_W-1:0];
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_action == ACT_LOAD) begin
                        if (s_first_of_set) begin
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            total_next = w_ext;
                            cnt_next   = CNT_W'(1);
                        end else if (cnt_reg != CNT_W'(MAX_PARTICLES)) begin
                            wr_en      = 1'b1;
                            total_next = total_reg + w_ext;
                            cnt_next   = cnt_reg + 1'b1;
                        end
                    end else if (cnt_reg == '0 || total_reg == '0) begin
                        res_idx_next  = '0;
                        res_zero_next = 1'b1;
                        state_next    = ST_FIN;
                    end else begin
                        mul_start     = 1'b1;
                        lo_next       = '0;
                        hi_next       = IDX_W'(cnt_reg - 1'b1);
                        res_zero_next = 1'b0;
                        state_next    = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (mul_stat.done) begin
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH: begin
                if (lo_reg < hi_reg) begin
                    state_next = ST_CMP;
                end else begin
                    res_idx_next = lo_reg;
                    state_next   = ST_FIN;
                end
            end
            ST_CMP: begin
                if (rd_data < target) begin
                    lo_next = mid + 1'b1;
                end else begin
                    hi_next = mid;
                end
                state_next = ST_SRCH;
            end
            ST_FIN: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            total_reg <= total_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        res_idx_reg  <= res_idx_next;
        res_zero_reg <= res_zero_next;
        if (out_load) begin
            m_idx_reg  <= res_idx_reg;
            m_zero_reg <= res_zero_reg;
        end
    end

    wrs_table #(
        .MAX_PARTICLES(MAX_PARTICLES),
        .SUM_W        (SUM_W)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(total_next),
        .rd_addr(mid),
        .rd_data(rd_data)
    );

    wrs_scale #(
        .SUM_W(SUM_W)
    ) u_scale (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (mul_start),
        .frac   (s_draw_fraction),
        .total  (total_reg),
        .stat   (mul_stat),
        .target (target)
    );

    assign idx_wide       = {{IDX_OUT_W{1'b0}}, m_idx_reg};
    assign m_valid        = m_valid_reg;
    assign m_chosen_index = idx_wide[IDX_OUT_W-1:0];
    assign m_zero_total   = m_zero_reg;

    `WRS_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= CNT_W'(MAX_PARTICLES),
        "count beyond table depth")
    `WRS_ASSERT(a_search_order, aclk, aresetn,
        (state_reg != ST_SRCH && state_reg != ST_CMP) || lo_reg <= hi_reg,
        "search bounds crossed")
    `WRS_ASSERT_NEXT(a_draw_start, aclk, aresetn,
        s_fire && s_action == ACT_DRAW && cnt_reg != '0 && total_reg != '0,
        state_reg == ST_MUL && mul_stat.busy, "draw did not start scaler")
    `WRS_ASSERT_NEXT(a_restart, aclk, aresetn,
        s_fire && s_action == ACT_LOAD && s_first_of_set,
        cnt_reg == CNT_W'(1), "restart did not reset count")
    `WRS_ASSERT(a_zero_idx, aclk, aresetn, !(m_valid && m_zero_total) || m_idx_reg == '0,
        "zero total with nonzero index")

endmodule

FILE: rtl/wrs_table.sv
`timescale 1ns / 1ps

module wrs_table #(
    parameter int MAX_PARTICLES = 1024,
    parameter int SUM_W         = 26
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(MAX_PARTICLES)-1:0] wr_addr,
    input  logic [SUM_W-1:0]                 wr_data,
    input  logic [$clog2(MAX_PARTICLES)-1:0] rd_addr,
    output logic [SUM_W-1:0]                 rd_data
);

    logic [SUM_W-1:0] mem [0:MAX_PARTICLES-1];
    logic [SUM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/wrs_scale.sv
`timescale 1ns / 1ps

module wrs_scale #(
    parameter int SUM_W = 26
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [15:0]           frac,
    input  logic [SUM_W-1:0]      total,
    output wrs_pkg::wrs_mul_stat_t stat,
    output logic [SUM_W-1:0]      target
);

    import wrs_pkg::*;

    localparam int ACC_W  = SUM_W + FRAC_W;
    localparam int STEPS  = FRAC_W / DIGIT_W;
    localparam int STEP_W = $clog2(STEPS);

    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [FRAC_W-1:0]      frac_reg;
    logic [STEP_W-1:0]      step_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic [DIGIT_W-1:0]     digit;
    logic [SUM_W+DIGIT_W-1:0] part;

    // radix-16 shift-add, most significant digit first
    assign digit    = frac_reg[FRAC_W-1 -: DIGIT_W];
    assign part     = digit * total;
    assign acc_next = (acc_reg << DIGIT_W) + ACC_W'(part);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg  <= '0;
            frac_reg <= frac;
        end else if (busy_reg) begin
            acc_reg  <= acc_next;
            frac_reg <= frac_reg << DIGIT_W;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign target    = acc_reg[ACC_W-1:FRAC_W];

endmodule
